### src/ptss_pkg.sv
// Package for the periodic task slot scheduler: command codes, slot states,
// field widths and the controller/datapath command and status structs.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package ptss_pkg;
    localparam int CMD_W = 2;
    localparam int PER_W = 16;
    localparam int ID_W  = 5;
    localparam int CNT_W = 32;
    localparam int MAX_RES = 16;

    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_FINISH = 2'd3;

    localparam logic [1:0] ST_FREE = 2'd0;
    localparam logic [1:0] ST_WAIT = 2'd1;
    localparam logic [1:0] ST_RUN  = 2'd2;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic [PER_W-1:0] period;
        logic [ID_W-1:0]  task_id;
        logic             keep;
    } in_item_t;

    typedef struct packed {
        logic            status;
        logic [ID_W-1:0] task_id_res;
        logic            due;
        logic            last;
    } out_item_t;

    // controller -> datapath
    typedef struct packed {
        logic load;       // capture input item
        logic exec;       // execute add/remove/finish, or bump tick count
        logic scan_start; // begin modulo on current scan slot
        logic scan_next;  // commit result of scan slot and advance
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic mod_done;
        logic scan_last;  // current slot is the final one
        logic hit;        // current slot becomes due
    } dp_stat_t;
endpackage
`default_nettype wire

### src/ptss_if.sv
// Valid/ready channel interface carrying one payload.
// Depends on nothing but its type parameter.
`timescale 1ns / 1ps
`default_nettype none
interface ptss_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

### src/ptss_ctrl.sv
// Controller state machine for the scheduler.
// Depends on ptss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptss_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    input  wire logic [1:0]         in_cmd,
    output logic                    in_ready,
    input  wire logic               out_free,   // output register empty or draining
    output logic                    emit,
    output logic                    emit_empty,
    output ptss_pkg::dp_cmd_t       dcmd,
    input  wire ptss_pkg::dp_stat_t dstat
);
    import ptss_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_MOD  = 3'd2;
    localparam logic [2:0] S_WAIT = 3'd3;
    localparam logic [2:0] S_EMPT = 3'd4;

    logic [2:0] state_reg, state_next;
    logic       tick_reg, tick_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            tick_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            tick_reg  <= tick_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        tick_next  = tick_reg;
        dcmd       = '0;
        in_ready   = 1'b0;
        emit       = 1'b0;
        emit_empty = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    dcmd.load  = 1'b1;
                    tick_next  = (in_cmd == CMD_TICK);
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (tick_reg)
                begin
                    dcmd.exec       = 1'b1;
                    dcmd.scan_start = 1'b1;
                    state_next      = S_MOD;
                end
                else if (out_free)
                begin
                    dcmd.exec  = 1'b1;
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_MOD:
            begin
                if (dstat.mod_done)
                    state_next = S_WAIT;
            end
            S_WAIT:
            begin
                // a hit must wait for space in the output register
                if (!dstat.hit || out_free)
                begin
                    dcmd.scan_next = 1'b1;
                    emit           = dstat.hit;
                    if (dstat.scan_last)
                        state_next = S_EMPT;
                    else
                    begin
                        dcmd.scan_start = 1'b1;
                        state_next      = S_MOD;
                    end
                end
            end
            S_EMPT:
            begin
                // sends the held final hit, or the empty result if there was none
                if (out_free)
                begin
                    emit_empty = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end
endmodule
`default_nettype wire

### src/ptss_dp.sv
// Datapath: slot table, tick counter, bit-serial modulo unit, output register.
// Depends on ptss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptss_dp #(
    parameter int SLOTS = 16
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire ptss_pkg::in_item_t  in_data,
    input  wire ptss_pkg::dp_cmd_t   dcmd,
    output ptss_pkg::dp_stat_t       dstat,
    input  wire logic                emit,
    input  wire logic                emit_empty,
    output logic                     out_free,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output ptss_pkg::out_item_t      out_data
);
    import ptss_pkg::*;

    localparam int IX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int UW   = $clog2(SLOTS + 1);
    localparam int RC_W = $clog2(MAX_RES + 1);
    localparam int BC_W = $clog2(CNT_W);

    in_item_t          item_reg;
    logic [1:0]        st_reg [SLOTS];
    logic [PER_W-1:0]  per_reg [SLOTS];
    logic [UW-1:0]     used_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [IX_W-1:0]   ix_reg;
    logic [RC_W-1:0]   nres_reg;
    logic              busy_reg;
    logic [BC_W-1:0]   bit_reg;
    logic [PER_W:0]    rem_reg;
    out_item_t         out_reg;
    logic              out_vld_reg;
    // Tick results are held back one hit so the final one can be marked last.
    logic              pend_reg;
    logic [ID_W-1:0]   pid_reg;

    // lowest free slot
    logic              free_found;
    logic [IX_W-1:0]   free_ix;
    always_comb
    begin
        free_found = 1'b0;
        free_ix    = '0;
        for (int i = SLOTS - 1; i >= 0; i--)
            if (st_reg[i] == ST_FREE)
            begin
                free_found = 1'b1;
                free_ix    = IX_W'(i);
            end
    end

    // id to slot index
    logic              id_ok;
    logic [IX_W-1:0]   id_ix;
    always_comb
    begin
        id_ok = (item_reg.task_id != '0) && ({1'b0, item_reg.task_id} <= 6'(SLOTS));
        id_ix = IX_W'(6'(SLOTS) - {1'b0, item_reg.task_id});
    end

    logic [ID_W-1:0] slot_id;
    assign slot_id = ID_W'(6'(SLOTS) - 6'(ix_reg));

    // one restoring step of cnt % period
    logic [PER_W:0]   rem_sh;
    logic [PER_W+1:0] rem_sub;
    assign rem_sh  = {rem_reg[PER_W-1:0], cnt_reg[bit_reg]};
    assign rem_sub = {1'b0, rem_sh} - {2'b00, per_reg[ix_reg]};

    logic hit;
    assign hit = (st_reg[ix_reg] == ST_WAIT) && (per_reg[ix_reg] != '0)
                 && (rem_reg == '0);

    assign dstat.mod_done  = !busy_reg;
    assign dstat.scan_last = (ix_reg == IX_W'(SLOTS - 1));
    assign dstat.hit       = hit;

    assign out_valid = out_vld_reg;
    assign out_free  = !out_vld_reg || out_ready;
    assign out_data  = out_reg;

    logic add_ok, rm_ok, fin_ok;
    assign add_ok = (item_reg.period != '0) && (used_reg < UW'(SLOTS)) && free_found;
    assign rm_ok  = id_ok && (st_reg[id_ix] != ST_FREE);
    assign fin_ok = id_ok && (st_reg[id_ix] == ST_RUN);

    always_ff @(posedge clk)
    begin
        if (dcmd.load)
            item_reg <= in_data;
        if (dcmd.exec && item_reg.cmd == CMD_ADD && add_ok)
            per_reg[free_ix] <= item_reg.period;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < SLOTS; i++)
                st_reg[i] <= ST_FREE;
            used_reg    <= '0;
            cnt_reg     <= '0;
            ix_reg      <= '0;
            nres_reg    <= '0;
            busy_reg    <= 1'b0;
            bit_reg     <= '0;
            rem_reg     <= '0;
            out_reg     <= '0;
            out_vld_reg <= 1'b0;
            pend_reg    <= 1'b0;
            pid_reg     <= '0;
        end
        else
        begin
            if (out_vld_reg && out_ready)
                out_vld_reg <= 1'b0;
            if (dcmd.exec)
            begin
                case (item_reg.cmd)
                    CMD_ADD:
                    begin
                        if (add_ok)
                        begin
                            st_reg[free_ix] <= ST_WAIT;
                            used_reg        <= used_reg + 1'b1;
                        end
                        out_reg     <= '{status: !add_ok,
                                         task_id_res: add_ok ? ID_W'(6'(SLOTS) - 6'(free_ix))
                                                             : '0,
                                         due: 1'b0, last: 1'b1};
                        out_vld_reg <= 1'b1;
                    end
                    CMD_REMOVE:
                    begin
                        if (rm_ok)
                        begin
                            st_reg[id_ix] <= ST_FREE;
                            used_reg      <= used_reg - 1'b1;
                        end
                        out_reg     <= '{status: !rm_ok,
                                         task_id_res: rm_ok ? item_reg.task_id : '0,
                                         due: 1'b0, last: 1'b1};
                        out_vld_reg <= 1'b1;
                    end
                    CMD_TICK:
                    begin
                        cnt_reg  <= cnt_reg + 1'b1;
                        ix_reg   <= '0;
                        nres_reg <= '0;
                        pend_reg <= 1'b0;
                    end
                    CMD_FINISH:
                    begin
                        if (fin_ok)
                        begin
                            st_reg[id_ix] <= item_reg.keep ? ST_WAIT : ST_FREE;
                            if (!item_reg.keep)
                                used_reg <= used_reg - 1'b1;
                        end
                        out_reg     <= '{status: !fin_ok,
                                         task_id_res: fin_ok ? item_reg.task_id : '0,
                                         due: 1'b0, last: 1'b1};
                        out_vld_reg <= 1'b1;
                    end
                    default: ;
                endcase
            end
            if (dcmd.scan_start)
            begin
                busy_reg <= 1'b1;
                bit_reg  <= BC_W'(CNT_W - 1);
                rem_reg  <= '0;
            end
            else if (busy_reg)
            begin
                rem_reg <= rem_sub[PER_W+1] ? rem_sh : rem_sub[PER_W:0];
                if (bit_reg == '0)
                    busy_reg <= 1'b0;
                else
                    bit_reg <= bit_reg - 1'b1;
            end
            if (dcmd.scan_next)
            begin
                if (hit)
                    st_reg[ix_reg] <= ST_RUN;
                if (!dstat.scan_last)
                    ix_reg <= ix_reg + 1'b1;
                if (emit && nres_reg < RC_W'(MAX_RES))
                begin
                    nres_reg <= nres_reg + 1'b1;
                    // a newer hit means the held one is not the last
                    if (pend_reg)
                    begin
                        out_reg.status      <= 1'b0;
                        out_reg.task_id_res <= pid_reg;
                        out_reg.due         <= 1'b1;
                        out_reg.last        <= 1'b0;
                        out_vld_reg         <= 1'b1;
                    end
                    pend_reg <= 1'b1;
                    pid_reg  <= slot_id;
                end
            end
            if (emit_empty)
            begin
                out_reg.status      <= 1'b0;
                out_reg.task_id_res <= pend_reg ? pid_reg : '0;
                out_reg.due         <= pend_reg;
                out_reg.last        <= 1'b1;
                out_vld_reg         <= 1'b1;
                pend_reg            <= 1'b0;
            end
        end
    end
endmodule
`default_nettype wire

### src/periodic_task_slot_scheduler.sv
// Top level of the periodic task slot scheduler.
// Depends on ptss_pkg, ptss_if, ptss_ctrl and ptss_dp.
//
// Add, remove and finish give one transaction each, subject to output
// back-pressure. In a tick, also subject to output back-pressure, each slot's
// period is tested against the tick count by a bit-serial remainder unit,
// one count bit per cycle.
// Due slots come out in index order, one transaction each; the final one has
// last set, or a single empty transaction comes out when nothing became due.
// One item is worked on at a time.
`timescale 1ns / 1ps
`default_nettype none
module periodic_task_slot_scheduler #(
    parameter int SLOTS = 16
) (
    input  wire logic clk,
    input  wire logic rst_n,
    ptss_if.sink      in_ch,
    ptss_if.source    out_ch
);
    import ptss_pkg::*;

    dp_cmd_t  dcmd;
    dp_stat_t dstat;
    logic     out_free, emit, emit_empty;

    ptss_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_ch.valid),
        .in_cmd     (in_ch.data.cmd),
        .in_ready   (in_ch.ready),
        .out_free   (out_free),
        .emit       (emit),
        .emit_empty (emit_empty),
        .dcmd       (dcmd),
        .dstat      (dstat)
    );

    ptss_dp #(.SLOTS(SLOTS)) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_data    (in_ch.data),
        .dcmd       (dcmd),
        .dstat      (dstat),
        .emit       (emit),
        .emit_empty (emit_empty),
        .out_free   (out_free),
        .out_valid  (out_ch.valid),
        .out_ready  (out_ch.ready),
        .out_data   (out_ch.data)
    );
endmodule
`default_nettype wire

### src/ptss_checker.sv
// Port-level checker for the scheduler, bound to the top level.
// Depends on ptss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ptss_checker (
    input wire logic                clk,
    input wire logic                rst_n,
    input wire logic                in_valid,
    input wire logic                in_ready,
    input wire logic                out_valid,
    input wire logic                out_ready,
    input wire ptss_pkg::out_item_t out_data
);
    import ptss_pkg::*;

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("output changed while stalled");

    a_due_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.due |-> !out_data.status && out_data.task_id_res != '0)
        else $error("due result with bad status or id");

    a_rej_id: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status |-> out_data.task_id_res == '0 && out_data.last)
        else $error("rejection carries id or is not last");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("accepted a second item at once");
endmodule

bind periodic_task_slot_scheduler ptss_checker u_chk (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_data  (out_ch.data)
);
`default_nettype wire

### bench/ptss_checker.sv
// Scoreboard for the periodic task slot scheduler: mirrors the slot table,
// predicts every result transaction and compares them in order.
// Depends on ptss_pkg.
`timescale 1ns / 1ps
module ptss_scoreboard #(
    parameter int SLOTS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  ptss_pkg::in_item_t  in_data,
    input  logic                out_valid,
    input  logic                out_ready,
    input  ptss_pkg::out_item_t out_data,
    output int                  errors,
    output int                  pending,
    output int                  n_items,
    output int                  n_due
);
    import ptss_pkg::*;

    logic [1:0]       slot_st [SLOTS];
    logic [PER_W-1:0] slot_per [SLOTS];
    logic [CNT_W-1:0] ticks;
    int               in_use;
    out_item_t        expected_q [$];

    function automatic out_item_t mk(logic st, logic [ID_W-1:0] id, logic d, logic l);
        out_item_t r;
        r.status = st;
        r.task_id_res = id;
        r.due = d;
        r.last = l;
        return r;
    endfunction

    task automatic schedule_item(in_item_t it);
        int s;
        int n;
        out_item_t tail;
        s = (it.task_id >= 1 && it.task_id <= SLOTS) ? SLOTS - int'(it.task_id) : -1;
        case (it.cmd)
            CMD_ADD: begin
                if (it.period == 0 || in_use >= SLOTS) begin
                    expected_q.push_back(mk(1'b1, '0, 1'b0, 1'b1));
                end else begin
                    for (int i = 0; i < SLOTS; i++) begin
                        if (slot_st[i] == ST_FREE) begin
                            slot_st[i] = ST_WAIT;
                            slot_per[i] = it.period;
                            in_use++;
                            expected_q.push_back(mk(1'b0, ID_W'(SLOTS - i), 1'b0, 1'b1));
                            break;
                        end
                    end
                end
            end
            CMD_REMOVE: begin
                if (s < 0 || slot_st[s] == ST_FREE) begin
                    expected_q.push_back(mk(1'b1, '0, 1'b0, 1'b1));
                end else begin
                    slot_st[s] = ST_FREE;
                    in_use--;
                    expected_q.push_back(mk(1'b0, it.task_id, 1'b0, 1'b1));
                end
            end
            CMD_TICK: begin
                ticks++;
                n = 0;
                for (int i = 0; i < SLOTS; i++) begin
                    if (slot_st[i] == ST_WAIT && slot_per[i] != 0
                        && ticks % CNT_W'(slot_per[i]) == 0) begin
                        slot_st[i] = ST_RUN;
                        if (n < MAX_RES) begin
                            expected_q.push_back(mk(1'b0, ID_W'(SLOTS - i), 1'b1, 1'b0));
                            n++;
                        end
                    end
                end
                if (n == 0) begin
                    expected_q.push_back(mk(1'b0, '0, 1'b0, 1'b1));
                end else begin
                    tail = expected_q.pop_back();
                    tail.last = 1'b1;
                    expected_q.push_back(tail);
                end
            end
            default: begin
                if (s < 0 || slot_st[s] != ST_RUN) begin
                    expected_q.push_back(mk(1'b1, '0, 1'b0, 1'b1));
                end else begin
                    if (it.keep) begin
                        slot_st[s] = ST_WAIT;
                    end else begin
                        slot_st[s] = ST_FREE;
                        in_use--;
                    end
                    expected_q.push_back(mk(1'b0, it.task_id, 1'b0, 1'b1));
                end
            end
        endcase
    endtask

    task automatic compare_result(out_item_t got);
        out_item_t want;
        if (expected_q.size() == 0) begin
            $error("unexpected result transaction %p", got);
            errors++;
            return;
        end
        want = expected_q.pop_front();
        if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            errors++;
        end
        if (got.task_id_res !== want.task_id_res) begin
            $error("task_id_res: expected %0d, got %0d", want.task_id_res, got.task_id_res);
            errors++;
        end
        if (got.due !== want.due) begin
            $error("due: expected %0d, got %0d", want.due, got.due);
            errors++;
        end
        if (got.last !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, got.last);
            errors++;
        end
        if (got.due === 1'b1)
            n_due++;
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            for (int i = 0; i < SLOTS; i++) begin
                slot_st[i] = ST_FREE;
                slot_per[i] = '0;
            end
            ticks = '0;
            in_use = 0;
            expected_q.delete();
            errors = 0;
            n_items = 0;
            n_due = 0;
        end else begin
            if (out_valid && out_ready)
                compare_result(out_data);
            if (in_valid && in_ready) begin
                schedule_item(in_data);
                n_items++;
            end
        end
        pending = expected_q.size();
    end
endmodule

### bench/tb_periodic_task_slot_scheduler.sv
// Testbench top for the periodic task slot scheduler: clock, reset, stimulus,
// output back-pressure and verdict. Depends on ptss_pkg, ptss_if, ptss_scoreboard.
`timescale 1ns / 1ps
module tb_periodic_task_slot_scheduler;
    import ptss_pkg::*;

    localparam int SLOTS = 16;
    localparam int STALL_LIMIT = 20000;
    localparam int LONG_HOLD = 3000;

    logic clk = 1'b0;
    logic rst_n;
    int   send_idle_pct;
    int   recv_stall_pct;
    logic hold_req;
    int   hold_left = 0;
    int   quiet_cycles = 0;
    int   errors, pending, n_items, n_due;
    logic [ID_W-1:0] due_ids [$];

    ptss_if #(.T(in_item_t))  in_ch ();
    ptss_if #(.T(out_item_t)) out_ch ();

    periodic_task_slot_scheduler #(.SLOTS(SLOTS)) dut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch)
    );

    ptss_scoreboard #(.SLOTS(SLOTS)) checker_i (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_data(in_ch.data),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_data(out_ch.data),
        .errors(errors), .pending(pending), .n_items(n_items), .n_due(n_due)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // receiver: random stalls, plus a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req)
            hold_left <= LONG_HOLD;
        else if (hold_left > 0)
            hold_left <= hold_left - 1;
        out_ch.ready <= (hold_left == 0 && !hold_req)
                        && ($urandom_range(99) >= recv_stall_pct);
    end

    // remember ids that went running, so finishes mostly hit
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready && out_ch.data.due)
            due_ids.push_back(out_ch.data.task_id_res);
        if (in_ch.valid && in_ch.ready || out_ch.valid && out_ch.ready || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic push(logic [1:0] c, logic [PER_W-1:0] p, logic [ID_W-1:0] id, logic k);
        in_item_t it;
        it.cmd = c;
        it.period = p;
        it.task_id = id;
        it.keep = k;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data <= it;
        do @(negedge clk); while (!in_ch.ready);
        @(posedge clk);
    endtask

    task automatic random_item();
        int r;
        logic [PER_W-1:0] p;
        logic [ID_W-1:0] id;
        r = $urandom_range(99);
        if ($urandom_range(9) < 7)
            p = PER_W'($urandom_range(6, 1));
        else if ($urandom_range(2) == 0)
            p = '0;
        else
            p = PER_W'($urandom_range(65535, 1));
        id = ($urandom_range(9) < 8) ? ID_W'($urandom_range(SLOTS, 1))
                                     : ID_W'($urandom_range(31));
        if (r < 28)
            push(CMD_ADD, p, id, 1'($urandom));
        else if (r < 38)
            push(CMD_REMOVE, p, id, 1'($urandom));
        else if (r < 72)
            push(CMD_TICK, p, id, 1'($urandom));
        else
        begin
            if (due_ids.size() > 0 && $urandom_range(9) < 7)
                id = due_ids.pop_front();
            push(CMD_FINISH, p, id, 1'($urandom_range(3) != 0));
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        hold_req = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: rejects, fill to full, overflow, ticks, bad ids
        push(CMD_ADD, 16'h0000, 5'd0, 1'b0);
        push(CMD_ADD, 16'hFFFF, 5'd0, 1'b0);
        for (int i = 0; i < 15; i++)
            push(CMD_ADD, (i % 2 == 0) ? 16'd1 : 16'd2, 5'd0, 1'b0);
        push(CMD_ADD, 16'h8000, 5'd31, 1'b1);
        push(CMD_FINISH, 16'd0, 5'd16, 1'b1);
        push(CMD_TICK, 16'd0, 5'd0, 1'b0);
        push(CMD_FINISH, 16'd0, 5'd15, 1'b1);
        push(CMD_FINISH, 16'd0, 5'd14, 1'b0);
        push(CMD_FINISH, 16'd0, 5'd0, 1'b1);
        push(CMD_REMOVE, 16'hFFFF, 5'd31, 1'b0);
        push(CMD_REMOVE, 16'd0, 5'd17, 1'b0);
        push(CMD_REMOVE, 16'd0, 5'd16, 1'b0);
        push(CMD_TICK, 16'd0, 5'd0, 1'b0);

        // random phases with different idle/stall mixes
        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 14 : 75) : 0;
            recv_stall_pct = (ph == 2 || ph == 3) ? ((ph == 3) ? 14 : 75) : 0;
            for (int n = 0; n < 84; n++)
            begin
                if (ph == 0 && n == 20)
                    hold_req <= 1'b1;
                else
                    hold_req <= 1'b0;
                random_item();
            end
        end
        hold_req <= 1'b0;
        in_ch.valid <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (600) @(posedge clk);

        $display("tb: %0d commands sent, %0d due results seen across idle/stall phases",
                 n_items, n_due);
        if (errors == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
